// ----- design/rmq_pkg.sv -----
// shared types and constants for the rotation matrix to quaternion core
package rmq_pkg;

   localparam int FracBitsDefault = 14;
   localparam int MagW = 17;
   localparam int QuoW = 16;
   localparam int Lanes = 3;

   // quaternion part positions
   localparam logic [1:0] PosX = 2'd0;
   localparam logic [1:0] PosY = 2'd1;
   localparam logic [1:0] PosZ = 2'd2;
   localparam logic [1:0] PosW = 2'd3;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
      logic               invalid;
   } rsp_type;

   // control that rides along the pipeline with each request
   typedef struct packed {
      logic             valid;
      logic             invalid;
      logic [1:0]       hpos;
      logic [Lanes-1:0] neg;
   } ctl_type;

endpackage

// ----- design/rmq_front.sv -----
// input stage: branch choice, square-root argument and dividend magnitudes
module rmq_front import rmq_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault,
   parameter int AW = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  req_type              req,
   output ctl_type              ctl_ff,
   output logic signed [AW-1:0] arg_ff,
   output logic [MagW-1:0]      mag_ff [Lanes]
);

   localparam logic signed [AW-1:0] One = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

   ctl_type              ctl_in;
   logic signed [AW-1:0] arg_in;
   logic [MagW-1:0]      mag_in [Lanes];

   logic signed [AW-1:0] a00, a11, a22, trace;
   logic signed [17:0]   e01, e02, e10, e12, e20, e21;
   logic signed [17:0]   d [Lanes];
   logic [1:0]           isel;

   // branch selection and lane dividends
   always_comb begin
      a00 = AW'(req.m00);
      a11 = AW'(req.m11);
      a22 = AW'(req.m22);
      e01 = 18'(req.m01);
      e02 = 18'(req.m02);
      e10 = 18'(req.m10);
      e12 = 18'(req.m12);
      e20 = 18'(req.m20);
      e21 = 18'(req.m21);
      trace = a00 + a11 + a22;
      if (req.m00 < req.m11) begin
         isel = (req.m11 < req.m22) ? PosZ : PosY;
      end else begin
         isel = (req.m00 < req.m22) ? PosZ : PosX;
      end
      ctl_in.valid = accept;
      ctl_in.invalid = 1'b0;
      if (trace > 0) begin
         ctl_in.hpos = PosW;
         arg_in = trace + One;
         d[0] = e21 - e12;
         d[1] = e02 - e20;
         d[2] = e10 - e01;
      end else begin
         ctl_in.hpos = isel;
         case (isel)
            PosX: begin
               arg_in = a00 - a11 - a22 + One;
               d[0] = e10 + e01;
               d[1] = e20 + e02;
               d[2] = e21 - e12;
            end
            PosY: begin
               arg_in = a11 - a22 - a00 + One;
               d[0] = e01 + e10;
               d[1] = e21 + e12;
               d[2] = e02 - e20;
            end
            default: begin
               arg_in = a22 - a00 - a11 + One;
               d[0] = e02 + e20;
               d[1] = e12 + e21;
               d[2] = e10 - e01;
            end
         endcase
         ctl_in.invalid = (arg_in <= 0);
      end
      for (int l = 0; l < Lanes; l++) begin
         ctl_in.neg[l] = d[l][17];
         mag_in[l] = d[l][17] ? MagW'(-d[l]) : MagW'(d[l]);
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      arg_ff <= arg_in;
      for (int l = 0; l < Lanes; l++) begin
         mag_ff[l] <= mag_in[l];
      end
   end

endmodule

// ----- design/rmq_sqrt_cell.sv -----
// one digit step of the integer square root
module rmq_sqrt_cell #(
   parameter int SW = 16,
   parameter int RW = 19
) (
   input  logic            clock,
   input  logic [2*SW-1:0] x_in,
   input  logic [RW-1:0]   rem_in,
   input  logic [SW-1:0]   root_in,
   output logic [2*SW-1:0] x_ff,
   output logic [RW-1:0]   rem_ff,
   output logic [SW-1:0]   root_ff
);

   logic [RW-1:0] cur, trial;
   logic          ge;

   // bring down two bits and try the next root bit
   always_comb begin
      cur = {rem_in[RW-3:0], x_in[2*SW-1 -: 2]};
      trial = RW'({root_in, 2'b01});
      ge = (cur >= trial);
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in << 2;
      rem_ff <= ge ? (cur - trial) : cur;
      root_ff <= {root_in[SW-2:0], ge};
   end

endmodule

// ----- design/rmq_div_cell.sv -----
// one quotient bit of a restoring divider
module rmq_div_cell import rmq_pkg::*; #(
   parameter int CW = 32,
   parameter int BIT = 15
) (
   input  logic            clock,
   input  logic [CW-1:0]   rem_in,
   input  logic [CW-1:0]   den_in,
   input  logic [QuoW-1:0] quo_in,
   output logic [CW-1:0]   rem_ff,
   output logic [CW-1:0]   den_ff,
   output logic [QuoW-1:0] quo_ff
);

   logic [CW-1:0]   shifted;
   logic            ge;
   logic [QuoW-1:0] quo_in_next;

   // compare against the shifted divisor
   always_comb begin
      shifted = den_in << BIT;
      ge = (rem_in >= shifted);
      quo_in_next = quo_in;
      quo_in_next[BIT] = ge;
   end

   always_ff @(posedge clock) begin
      rem_ff <= ge ? (rem_in - shifted) : rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in_next;
   end

endmodule

// ----- design/rotation_matrix_to_quaternion_core.sv -----
// top level: pipelined rotation matrix to quaternion conversion
// Takes one matrix per clock cycle and never asserts busy outside reset. Each
// result appears on rsp_payload with rsp_strobe high for one cycle, after its
// request has passed the input stage register, the square-root cell row (one
// root bit per cell, with SW the root width: FRAC_BITS + 2 root digits for the
// default format), the divider setup register, a row of sixteen divider cells
// per quotient lane and the output register. The receiver cannot stall, so
// results must be taken as they appear.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int AW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
   localparam int XW = AW - 1 + FRAC_BITS;
   localparam int SW = (XW + 1) / 2;
   localparam int RW = SW + 3;
   localparam int CW = (FRAC_BITS + 18 > SW + 16) ? FRAC_BITS + 18 : SW + 16;

   logic accept;

   ctl_type              ctl_f;
   logic signed [AW-1:0] arg_f;
   logic [MagW-1:0]      mag_f [Lanes];

   logic [2*SW-1:0] x_s    [SW+1];
   logic [RW-1:0]   rem_s  [SW+1];
   logic [SW-1:0]   root_s [SW+1];
   ctl_type         ctl_s  [SW+1];
   logic [MagW-1:0] mag_s  [SW+1][Lanes];

   logic [CW-1:0]   rem_q  [Lanes][QuoW+1];
   logic [CW-1:0]   den_q  [Lanes][QuoW+1];
   logic [QuoW-1:0] quo_q  [Lanes][QuoW+1];
   ctl_type         ctl_q  [QuoW+1];
   logic [SW-1:0]   half_q [QuoW+1];

   rsp_type rsp_in, rsp_ff;
   logic    strobe_ff;
   logic [15:0] lane_val [Lanes];
   logic [15:0] part [4];
   logic [15:0] half_sat;
   logic [1:0]  lane;

   // handshake
   assign busy = reset;
   assign accept = start & ~busy;

   // input stage
   rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .ctl_ff (ctl_f),
      .arg_ff (arg_f),
      .mag_ff (mag_f)
   );

   // square-root row feed
   assign x_s[0] = (2*SW)'({arg_f[AW-2:0], {FRAC_BITS{1'b0}}});
   assign rem_s[0] = '0;
   assign root_s[0] = '0;
   assign ctl_s[0] = ctl_f;
   assign mag_s[0] = mag_f;

   // square-root cell row with control and dividends riding alongside
   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      rmq_sqrt_cell #(.SW(SW), .RW(RW)) u_cell (
         .clock   (clock),
         .x_in    (x_s[k]),
         .rem_in  (rem_s[k]),
         .root_in (root_s[k]),
         .x_ff    (x_s[k+1]),
         .rem_ff  (rem_s[k+1]),
         .root_ff (root_s[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_s[k+1] <= '0;
         end else begin
            ctl_s[k+1] <= ctl_s[k];
         end
      end
      always_ff @(posedge clock) begin
         mag_s[k+1] <= mag_s[k];
      end
   end

   // divider setup: rounded numerator, doubled root and half root
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_q[0] <= '0;
      end else begin
         ctl_q[0] <= ctl_s[SW];
      end
   end

   always_ff @(posedge clock) begin
      half_q[0] <= SW'(((SW+1)'(root_s[SW]) + (SW+1)'(1)) >> 1);
   end

   // divider cell rows, one per lane
   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      always_ff @(posedge clock) begin
         rem_q[l][0] <= CW'({mag_s[SW][l], {FRAC_BITS{1'b0}}}) + CW'(root_s[SW]);
         den_q[l][0] <= CW'({root_s[SW], 1'b0});
         quo_q[l][0] <= '0;
      end
      for (genvar k = 0; k < QuoW; k++) begin : g_div
         rmq_div_cell #(.CW(CW), .BIT(QuoW - 1 - k)) u_cell (
            .clock  (clock),
            .rem_in (rem_q[l][k]),
            .den_in (den_q[l][k]),
            .quo_in (quo_q[l][k]),
            .rem_ff (rem_q[l][k+1]),
            .den_ff (den_q[l][k+1]),
            .quo_ff (quo_q[l][k+1])
         );
      end
   end

   // control and half root alongside the divider
   for (genvar k = 0; k < QuoW; k++) begin : g_dctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_q[k+1] <= '0;
         end else begin
            ctl_q[k+1] <= ctl_q[k];
         end
      end
      always_ff @(posedge clock) begin
         half_q[k+1] <= half_q[k];
      end
   end

   // sign, saturation and placement of the parts
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         if (quo_q[l][QuoW][QuoW-1]) begin
            lane_val[l] = ctl_q[QuoW].neg[l] ? 16'h8000 : 16'h7fff;
         end else if (ctl_q[QuoW].neg[l]) begin
            lane_val[l] = -quo_q[l][QuoW];
         end else begin
            lane_val[l] = quo_q[l][QuoW];
         end
      end
      half_sat = (half_q[QuoW] > SW'(16'h7fff)) ? 16'h7fff : 16'(half_q[QuoW]);
      for (int p = 0; p < 4; p++) begin
         lane = 2'(p) - ((2'(p) > ctl_q[QuoW].hpos) ? 2'd1 : 2'd0);
         if (ctl_q[QuoW].invalid) begin
            part[p] = '0;
         end else if (2'(p) == ctl_q[QuoW].hpos) begin
            part[p] = half_sat;
         end else begin
            part[p] = lane_val[lane];
         end
      end
      rsp_in.qx = part[PosX];
      rsp_in.qy = part[PosY];
      rsp_in.qz = part[PosZ];
      rsp_in.qw = part[PosW];
      rsp_in.invalid = ctl_q[QuoW].invalid;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_q[QuoW].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
